// ===== hw/rtl/kefc_pkg.sv =====
// Shared types, constants and key lookup tables for the keypad event FIFO.
`timescale 1ns / 1ps

package kefc_pkg;

  localparam int FIFO_DEPTH  = 32;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FILL_W      = 5;
  localparam int CHAR_W      = 7;
  localparam int CODE_W      = 8;
  localparam int NUM_KEYS    = 35;
  localparam int KEY_W       = $clog2(NUM_KEYS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] MARK_SYM   = 7'h1A;
  localparam logic [CHAR_W-1:0] MARK_SHIFT = 7'h19;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CONSUME,
    OP_SYM,
    OP_SHIFT,
    OP_PUSH
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             level;  // press (1) or release (0) for modifier keys
    logic [KEY_W-1:0] key;
  } cmd_t;

  // Indexed by key number k = code - 1 (release) or code - 129 (press).
  // Each row of the 4x10 layout appears right to left, since column = 9 - k % 10.
  localparam logic [CHAR_W-1:0] BASE_LUT [NUM_KEYS] = '{
    7'h70, 7'h6F, 7'h69, 7'h75, 7'h79, 7'h74, 7'h72, 7'h65, 7'h77, 7'h71,
    7'h08, 7'h6C, 7'h6B, 7'h6A, 7'h68, 7'h67, 7'h66, 7'h64, 7'h73, 7'h61,
    7'h45, 7'h24, 7'h6D, 7'h6E, 7'h62, 7'h76, 7'h63, 7'h78, 7'h7A, 7'h1A,
    7'h20, 7'h1A, 7'h20, 7'h1B, 7'h19
  };

  localparam logic [CHAR_W-1:0] SHIFT_LUT [NUM_KEYS] = '{
    7'h50, 7'h4F, 7'h49, 7'h55, 7'h59, 7'h54, 7'h52, 7'h45, 7'h57, 7'h51,
    7'h08, 7'h4C, 7'h4B, 7'h4A, 7'h48, 7'h47, 7'h46, 7'h44, 7'h53, 7'h41,
    7'h45, 7'h24, 7'h4D, 7'h4E, 7'h42, 7'h56, 7'h43, 7'h58, 7'h5A, 7'h1A,
    7'h20, 7'h1A, 7'h20, 7'h1B, 7'h19
  };

  localparam logic [CHAR_W-1:0] SYM_LUT [NUM_KEYS] = '{
    7'h40, 7'h2B, 7'h2D, 7'h5F, 7'h29, 7'h28, 7'h33, 7'h32, 7'h31, 7'h23,
    7'h08, 7'h22, 7'h27, 7'h3B, 7'h3A, 7'h2F, 7'h36, 7'h35, 7'h34, 7'h2A,
    7'h45, 7'h24, 7'h2E, 7'h2C, 7'h21, 7'h3F, 7'h39, 7'h38, 7'h37, 7'h1A,
    7'h20, 7'h1A, 7'h20, 7'h1B, 7'h19
  };

  function automatic logic [PTR_W-1:0] ptr_bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/kefc_if.sv =====
// Valid/ready channel interfaces for key events and status results.
`timescale 1ns / 1ps

interface kefc_in_if;
  import kefc_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [CODE_W-1:0] event_code;

  modport source (output valid, action, event_code, input ready);
  modport sink (input valid, action, event_code, output ready);
  modport monitor (input valid, ready, action, event_code);
endinterface

interface kefc_out_if;
  import kefc_pkg::*;

  logic              valid;
  logic              ready;
  logic              head_valid;
  logic [CHAR_W-1:0] head_char;
  logic [FILL_W-1:0] fill_count;
  logic              char_pushed;
  logic              oldest_dropped;
  logic              sym_active;
  logic              shift_active;

  modport source (
    output valid, head_valid, head_char, fill_count, char_pushed, oldest_dropped,
           sym_active, shift_active,
    input  ready
  );
  modport sink (
    input  valid, head_valid, head_char, fill_count, char_pushed, oldest_dropped,
           sym_active, shift_active,
    output ready
  );
  modport monitor (
    input valid, ready, head_valid, head_char, fill_count, char_pushed, oldest_dropped,
          sym_active, shift_active
  );
endinterface

// ===== hw/rtl/kefc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kefc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kefc_front.sv =====
// Front end: takes key events and classifies them into back-end commands.
`timescale 1ns / 1ps

module kefc_front (
  kefc_in_if.sink          evt_i,
  output logic             cmd_valid_o,
  output kefc_pkg::cmd_t   cmd_o,
  input  logic             cmd_ready_i
);
  import kefc_pkg::*;

  logic [CODE_W-2:0] low_code;
  logic              key_hit;
  logic [KEY_W-1:0]  key_idx;

  // Releases and presses share the low seven bits; bit 7 marks a press.
  assign low_code = evt_i.event_code[CODE_W-2:0];
  assign key_hit  = (low_code >= 7'd1) && (low_code <= 7'(NUM_KEYS));
  assign key_idx  = KEY_W'(low_code - 7'd1);

  always_comb begin
    cmd_o.op    = OP_NOP;
    cmd_o.level = evt_i.event_code[CODE_W-1];
    cmd_o.key   = '0;
    if (evt_i.action) begin
      cmd_o.op = OP_CONSUME;
    end else if (key_hit) begin
      cmd_o.key = key_idx;
      if (BASE_LUT[key_idx] == MARK_SYM) begin
        cmd_o.op = OP_SYM;
      end else if (BASE_LUT[key_idx] == MARK_SHIFT) begin
        cmd_o.op = OP_SHIFT;
      end else if (evt_i.event_code[CODE_W-1]) begin
        cmd_o.op = OP_PUSH;
      end
    end
  end

  assign cmd_valid_o = evt_i.valid;
  assign evt_i.ready = cmd_ready_i;

endmodule

// ===== hw/rtl/kefc_cmd_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module kefc_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  kefc_pkg::cmd_t in_cmd_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output kefc_pkg::cmd_t out_cmd_o,
  input  logic           out_ready_i
);
  import kefc_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  function automatic logic [QPTR_W-1:0] qbump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = slot_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = push ? qbump(wr_q) : wr_q;
    rd_d  = pop ? qbump(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/kefc_back.sv =====
// Back end: modifier flags, character ring and the result register.
`timescale 1ns / 1ps

module kefc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  kefc_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  kefc_out_if.source     res_o
);
  import kefc_pkg::*;

  localparam int DIFF_W = PTR_W + 1;

  logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d, wp_next;
  logic              sym_q, sym_d, shift_q, shift_d;
  logic              step;
  logic              pushed, dropped;
  logic [CHAR_W-1:0] push_char;
  logic [DIFF_W-1:0] diff;
  logic              bypass;
  logic [CHAR_W-1:0] ram_rdata;

  logic              res_valid_q;
  logic              head_valid_q;
  logic [FILL_W-1:0] fill_q;
  logic              pushed_q, dropped_q;
  logic              byp_q;
  logic [CHAR_W-1:0] byp_char_q;

  assign cmd_ready_o = !res_valid_q || res_o.ready;
  assign step        = cmd_valid_i && cmd_ready_o;
  assign wp_next     = ptr_bump(wp_q);

  always_comb begin
    if (shift_q) begin
      push_char = SHIFT_LUT[cmd_i.key];
    end else if (sym_q) begin
      push_char = SYM_LUT[cmd_i.key];
    end else begin
      push_char = BASE_LUT[cmd_i.key];
    end
  end

  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    sym_d   = sym_q;
    shift_d = shift_q;
    pushed  = 1'b0;
    dropped = 1'b0;
    unique case (cmd_i.op)
      OP_CONSUME: begin
        if (wp_q != rp_q) begin
          rp_d = ptr_bump(rp_q);
        end
      end
      OP_SYM:   sym_d   = cmd_i.level;
      OP_SHIFT: shift_d = cmd_i.level;
      OP_PUSH: begin
        pushed = 1'b1;
        wp_d   = wp_next;
        // ring full: advance the read side over the oldest character
        if (wp_next == rp_q) begin
          rp_d    = ptr_bump(rp_q);
          dropped = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign diff = (wp_d >= rp_d) ? ({1'b0, wp_d} - {1'b0, rp_d})
                               : ({1'b0, wp_d} + DIFF_W'(FIFO_DEPTH) - {1'b0, rp_d});

  // A push into an empty ring makes the new character the head in the same step.
  assign bypass = pushed && (rp_d == wp_q);

  kefc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (step && pushed),
    .waddr_i (wp_q),
    .wdata_i (push_char),
    .re_i    (step),
    .raddr_i (rp_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      sym_q       <= 1'b0;
      shift_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (step) begin
        wp_q        <= wp_d;
        rp_q        <= rp_d;
        sym_q       <= sym_d;
        shift_q     <= shift_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      head_valid_q <= (wp_d != rp_d);
      fill_q       <= FILL_W'(diff);
      pushed_q     <= pushed;
      dropped_q    <= dropped;
      byp_q        <= bypass;
      byp_char_q   <= push_char;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.head_valid     = head_valid_q;
  assign res_o.head_char      = head_valid_q ? (byp_q ? byp_char_q : ram_rdata) : '0;
  assign res_o.fill_count     = fill_q;
  assign res_o.char_pushed    = pushed_q;
  assign res_o.oldest_dropped = dropped_q;
  assign res_o.sym_active     = sym_q;
  assign res_o.shift_active   = shift_q;

endmodule

// ===== hw/rtl/keypad_event_to_char_fifo.sv =====
// Keypad event decoder feeding a character FIFO: top level.
//
// evt_i carries one item per transfer: action 1 consumes the oldest
// buffered character, action 0 carries a raw key code (1..35 release,
// 129..163 press, anything else ignored). Sym and shift keys only move
// the held modifier flags; other presses push one 7-bit character into a
// ring of FIFO_DEPTH slots (FIFO_DEPTH-1 usable), dropping the oldest
// character when the ring is full.
// res_o returns exactly one status item per input transfer: head character,
// fill level, push/drop flags and the modifier flags after that item.
// A result passes the command queue and then the result register to res_o.
// Throughput: one item per cycle while res_o is not stalled, set by the
// single back-end step that updates the ring pointers and the store RAM.
// A two-entry command queue and the result register decouple the sides:
// when res_o stalls the queue takes at most two more transfers, then
// evt_i.ready drops until the waiting result is taken. Reset empties the
// ring, clears both modifiers and the queue; the store needs no clearing pass.
`timescale 1ns / 1ps

module keypad_event_to_char_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  kefc_in_if.sink    evt_i,
  kefc_out_if.source res_o
);
  import kefc_pkg::*;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  kefc_front u_front (
    .evt_i       (evt_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  kefc_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_cmd_i    (front_cmd),
    .in_ready_o  (front_ready),
    .out_valid_o (back_valid),
    .out_cmd_o   (back_cmd),
    .out_ready_i (back_ready)
  );

  kefc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_i       (back_cmd),
    .cmd_ready_o (back_ready),
    .res_o       (res_o)
  );

endmodule

// ===== hw/rtl/kefc_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module kefc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic                          head_valid_i,
  input logic [kefc_pkg::CHAR_W-1:0]   head_char_i,
  input logic [kefc_pkg::FILL_W-1:0]   fill_count_i,
  input logic                          char_pushed_i,
  input logic                          oldest_dropped_i
);
  import kefc_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(fill_count_i)
      && $stable(head_char_i) && $stable(head_valid_i))
    else $error("result changed while stalled");

  a_head_vs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (head_valid_i == (fill_count_i != '0)))
    else $error("head_valid disagrees with fill_count");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !head_valid_i |-> head_char_i == '0)
    else $error("empty ring shows a head character");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && oldest_dropped_i |->
      char_pushed_i && fill_count_i == FILL_W'(FIFO_DEPTH - 1))
    else $error("drop without a push into a full ring");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> fill_count_i <= FILL_W'(FIFO_DEPTH - 1))
    else $error("fill level beyond ring capacity");

endmodule

bind keypad_event_to_char_fifo kefc_checker u_kefc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .head_valid_i     (res_o.head_valid),
  .head_char_i      (res_o.head_char),
  .fill_count_i     (res_o.fill_count),
  .char_pushed_i    (res_o.char_pushed),
  .oldest_dropped_i (res_o.oldest_dropped)
);

// ===== tb/kefc_tb_pkg.sv =====
// Action codes and key numbering shared by the keypad FIFO testbench files.
`timescale 1ns / 1ps

package kefc_tb_pkg;
  import kefc_pkg::*;

  localparam logic ACT_KEY     = 1'b0;
  localparam logic ACT_CONSUME = 1'b1;

  localparam int RELEASE_FIRST = 1;
  localparam int PRESS_FIRST   = 129;

  // key numbers of the modifier keys (two sym keys, one shift key)
  localparam int KEY_SYM_LEFT  = 29;
  localparam int KEY_SYM_RIGHT = 31;
  localparam int KEY_SHIFT     = 34;

  function automatic logic [CODE_W-1:0] press_code(input int k);
    return CODE_W'(PRESS_FIRST + k);
  endfunction

  function automatic logic [CODE_W-1:0] release_code(input int k);
    return CODE_W'(RELEASE_FIRST + k);
  endfunction

endpackage

// ===== tb/kefc_status_checker.sv =====
// Checker: predicts the status result of each key event transfer and compares it.
`timescale 1ns / 1ps

module kefc_status_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  kefc_in_if.monitor   evt_i,
  kefc_out_if.monitor  res_i,
  output int           mismatch_count_o,
  output int           pending_o
);
  import kefc_pkg::*;
  import kefc_tb_pkg::*;

  localparam int KEY_ROWS = 4;
  localparam int KEY_COLS = 10;
  localparam int MAX_PRINTS = 50;

  localparam byte unsigned CH_BS    = 8'h08;
  localparam byte unsigned CH_ESC   = 8'h1B;
  localparam byte unsigned CH_SYM   = 8'(MARK_SYM);
  localparam byte unsigned CH_SHIFT = 8'(MARK_SHIFT);

  localparam byte unsigned BASE_MAP [KEY_ROWS][KEY_COLS] = '{
    '{"q", "w", "e", "r", "t", "y", "u", "i", "o", "p"},
    '{"a", "s", "d", "f", "g", "h", "j", "k", "l", CH_BS},
    '{CH_SYM, "z", "x", "c", "v", "b", "n", "m", "$", "E"},
    '{" ", " ", " ", " ", " ", CH_SHIFT, CH_ESC, " ", CH_SYM, " "}
  };

  localparam byte unsigned SYM_MAP [KEY_ROWS][KEY_COLS] = '{
    '{"#", "1", "2", "3", "(", ")", "_", "-", "+", "@"},
    '{"*", "4", "5", "6", "/", ":", ";", "'", "\"", CH_BS},
    '{CH_SYM, "7", "8", "9", "?", "!", ",", ".", "$", "E"},
    '{" ", " ", " ", " ", " ", CH_SHIFT, CH_ESC, " ", CH_SYM, " "}
  };

  localparam byte unsigned SHIFT_MAP [KEY_ROWS][KEY_COLS] = '{
    '{"Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P"},
    '{"A", "S", "D", "F", "G", "H", "J", "K", "L", CH_BS},
    '{CH_SYM, "Z", "X", "C", "V", "B", "N", "M", "$", "E"},
    '{" ", " ", " ", " ", " ", CH_SHIFT, CH_ESC, " ", CH_SYM, " "}
  };

  typedef struct packed {
    logic              head_valid;
    logic [CHAR_W-1:0] head_char;
    logic [FILL_W-1:0] fill_count;
    logic              char_pushed;
    logic              oldest_dropped;
    logic              sym_active;
    logic              shift_active;
  } key_status_t;

  logic [CHAR_W-1:0] ring_store [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic              sym_down;
  logic              shift_down;
  key_status_t       pending_status_q [$];
  int                results_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count_o++;
    if (mismatch_count_o <= MAX_PRINTS)
      $display("[%0t] result %0d: %s got 0x%0h want 0x%0h", $time, results_seen, what, got,
               want);
  endtask

  // Applies one transfer to the shadow ring and modifiers, queues the status.
  task automatic decode_and_queue_status(input logic act, input logic [CODE_W-1:0] code);
    key_status_t st;
    int          k;
    int          row;
    int          col;
    bit          press;
    bit          known;
    byte unsigned base_ch;
    byte unsigned ch;
    st = '0;
    press = 1'b0;
    known = 1'b0;
    k = 0;
    if (act == ACT_CONSUME) begin
      if (wr_ptr != rd_ptr) rd_ptr = rd_ptr + 1'b1;
    end else begin
      if (code >= RELEASE_FIRST && code < RELEASE_FIRST + NUM_KEYS) begin
        k = code - RELEASE_FIRST;
        known = 1'b1;
      end else if (code >= PRESS_FIRST && code < PRESS_FIRST + NUM_KEYS) begin
        k = code - PRESS_FIRST;
        press = 1'b1;
        known = 1'b1;
      end
      if (known) begin
        row = k / KEY_COLS;
        col = KEY_COLS - 1 - (k % KEY_COLS);
        base_ch = BASE_MAP[row][col];
        if (base_ch == CH_SYM) begin
          sym_down = press;
        end else if (base_ch == CH_SHIFT) begin
          shift_down = press;
        end else if (press) begin
          if (shift_down) ch = SHIFT_MAP[row][col];
          else if (sym_down) ch = SYM_MAP[row][col];
          else ch = base_ch;
          // ring full: the oldest character makes room
          if (PTR_W'(wr_ptr + 1'b1) == rd_ptr) begin
            rd_ptr = rd_ptr + 1'b1;
            st.oldest_dropped = 1'b1;
          end
          ring_store[wr_ptr] = ch[CHAR_W-1:0];
          wr_ptr = wr_ptr + 1'b1;
          st.char_pushed = 1'b1;
        end
      end
    end
    st.head_valid   = (wr_ptr != rd_ptr);
    st.head_char    = st.head_valid ? ring_store[rd_ptr] : '0;
    st.fill_count   = FILL_W'(wr_ptr - rd_ptr);
    st.sym_active   = sym_down;
    st.shift_active = shift_down;
    pending_status_q.push_back(st);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_status_t want;
    if (!rst_ni) begin
      wr_ptr = '0;
      rd_ptr = '0;
      sym_down = 1'b0;
      shift_down = 1'b0;
      pending_status_q.delete();
      pending_o = 0;
      results_seen = 0;
      mismatch_count_o = 0;
    end else begin
      if (evt_i.valid && evt_i.ready) decode_and_queue_status(evt_i.action, evt_i.event_code);
      if (res_i.valid && res_i.ready) begin
        if (pending_status_q.size() == 0) begin
          report_mismatch("result with no transfer waiting", int'(res_i.fill_count), 0);
        end else begin
          want = pending_status_q.pop_front();
          if (res_i.head_valid !== want.head_valid)
            report_mismatch("head_valid", int'(res_i.head_valid), int'(want.head_valid));
          if (res_i.head_char !== want.head_char)
            report_mismatch("head_char", int'(res_i.head_char), int'(want.head_char));
          if (res_i.fill_count !== want.fill_count)
            report_mismatch("fill_count", int'(res_i.fill_count), int'(want.fill_count));
          if (res_i.char_pushed !== want.char_pushed)
            report_mismatch("char_pushed", int'(res_i.char_pushed), int'(want.char_pushed));
          if (res_i.oldest_dropped !== want.oldest_dropped)
            report_mismatch("oldest_dropped", int'(res_i.oldest_dropped),
                            int'(want.oldest_dropped));
          if (res_i.sym_active !== want.sym_active)
            report_mismatch("sym_active", int'(res_i.sym_active), int'(want.sym_active));
          if (res_i.shift_active !== want.shift_active)
            report_mismatch("shift_active", int'(res_i.shift_active),
                            int'(want.shift_active));
        end
        results_seen++;
      end
      pending_o = pending_status_q.size();
    end
  end

endmodule

// ===== tb/tb_keypad_event_to_char_fifo.sv =====
// Testbench top: clock, reset, key event stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_keypad_event_to_char_fifo;
  import kefc_pkg::*;
  import kefc_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 880;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 150;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_PCT      = 33;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   pending_count;
  int   sent_count;
  int   cycle_count = 0;
  logic hold_results;

  kefc_in_if  evt_if ();
  kefc_out_if res_if ();

  keypad_event_to_char_fifo u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  kefc_status_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_i            (evt_if),
    .res_i            (res_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // no random idling on either side in this window
  function automatic bit calm_window();
    return sent_count >= 400 && sent_count < 600;
  endfunction

  function automatic bit is_modifier(input int k);
    return k == KEY_SYM_LEFT || k == KEY_SYM_RIGHT || k == KEY_SHIFT;
  endfunction

  function automatic bit is_key_code(input logic [CODE_W-1:0] code);
    return (code >= RELEASE_FIRST && code < RELEASE_FIRST + NUM_KEYS) ||
           (code >= PRESS_FIRST && code < PRESS_FIRST + NUM_KEYS);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) res_if.ready = 1'b0;
    else res_if.ready = !(hold_results ||
                          (!calm_window() && $urandom_range(99) < IDLE_PCT));
  end

  // long result stall while events keep coming: command queue fills, input stalls
  initial begin
    hold_results = 1'b0;
    wait (rst_ni === 1'b1);
    wait (sent_count >= HOLD_AFTER);
    hold_results = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_results = 1'b0;
  end

  task automatic send_item(input logic act, input logic [CODE_W-1:0] code);
    @(negedge clk_i);
    while (!calm_window() && $urandom_range(99) < IDLE_PCT) begin
      evt_if.valid = 1'b0;
      evt_if.event_code = CODE_W'($urandom_range(255));
      @(negedge clk_i);
    end
    evt_if.valid = 1'b1;
    evt_if.action = act;
    evt_if.event_code = code;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    sent_count++;
  endtask

  initial begin
    int useful;
    int k;
    int r;
    int consume_pct;
    logic [CODE_W-1:0] code;
    rst_ni = 1'b0;
    evt_if.valid = 1'b0;
    evt_if.action = ACT_KEY;
    evt_if.event_code = '0;
    sent_count = 0;
    useful = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty consume, ignored codes, extremes, modifier interplay
    send_item(ACT_CONSUME, 8'hFF);
    send_item(ACT_KEY, 8'd0);
    send_item(ACT_KEY, 8'd36);
    send_item(ACT_KEY, 8'd128);
    send_item(ACT_KEY, 8'd164);
    send_item(ACT_KEY, 8'd255);
    send_item(ACT_KEY, press_code(0));
    send_item(ACT_KEY, release_code(0));
    send_item(ACT_KEY, press_code(KEY_SHIFT));
    send_item(ACT_KEY, press_code(1));
    send_item(ACT_KEY, press_code(KEY_SYM_LEFT));
    send_item(ACT_KEY, press_code(2));
    send_item(ACT_KEY, release_code(KEY_SHIFT));
    send_item(ACT_KEY, press_code(2));
    send_item(ACT_KEY, press_code(KEY_SYM_RIGHT));
    // releasing one sym key clears sym although the other is still down
    send_item(ACT_KEY, release_code(KEY_SYM_LEFT));
    send_item(ACT_KEY, press_code(2));
    send_item(ACT_KEY, release_code(KEY_SYM_RIGHT));
    send_item(ACT_KEY, press_code(10));
    send_item(ACT_KEY, press_code(11));
    send_item(ACT_KEY, press_code(NUM_KEYS - 2));
    send_item(ACT_KEY, release_code(NUM_KEYS - 1));
    send_item(ACT_CONSUME, 8'h00);
    send_item(ACT_CONSUME, 8'h5A);

    // random: alternating fill-heavy and drain-heavy segments to hit full and empty
    while (useful < RANDOM_ITEMS) begin
      consume_pct = ((useful / 100) % 2 == 0) ? 8 : 45;
      r = $urandom_range(99);
      if (r < consume_pct) begin
        send_item(ACT_CONSUME, CODE_W'($urandom_range(255)));
        useful++;
      end else if (r < consume_pct + 8) begin
        code = CODE_W'($urandom_range(255));
        send_item(ACT_KEY, code);
        if (is_key_code(code)) useful++;
      end else if (r < consume_pct + 16) begin
        case ($urandom_range(2))
          0: k = KEY_SYM_LEFT;
          1: k = KEY_SYM_RIGHT;
          default: k = KEY_SHIFT;
        endcase
        send_item(ACT_KEY, $urandom_range(1) ? press_code(k) : release_code(k));
        useful++;
      end else if (r < consume_pct + 22) begin
        send_item(ACT_KEY, release_code($urandom_range(NUM_KEYS - 1)));
        useful++;
      end else begin
        k = $urandom_range(NUM_KEYS - 1);
        while (is_modifier(k)) k = $urandom_range(NUM_KEYS - 1);
        send_item(ACT_KEY, press_code(k));
        useful++;
      end
    end

    @(negedge clk_i);
    evt_if.valid = 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
